FILE: rtl/core/bbc_pkg.sv
// package for the bilevel bitmap compose block
// types, sizes and codes shared by bbc_if, bbc_ctrl, bbc_dp and the top level; no dependencies
`default_nettype none
package bbc_pkg;
  localparam int DST_MAX_DIM = 512;
  localparam int SRC_MAX_DIM = 256;
  localparam int DST_DEPTH = ((DST_MAX_DIM + 7) / 8) * DST_MAX_DIM;
  localparam int SRC_DEPTH = ((SRC_MAX_DIM + 7) / 8) * SRC_MAX_DIM;
  localparam int DA_W = $clog2(DST_DEPTH);
  localparam int SA_W = $clog2(SRC_DEPTH);

  typedef enum logic [1:0] {
    FUNC_WR_DST = 2'd0, FUNC_WR_SRC = 2'd1, FUNC_COMPOSE = 2'd2, FUNC_RD_DST = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OP_OR = 3'd0, OP_AND = 3'd1, OP_XOR = 3'd2, OP_XNOR = 3'd3, OP_REPLACE = 3'd4
  } op_t;

  localparam logic [1:0] REG_DST_W = 2'd0;
  localparam logic [1:0] REG_DST_H = 2'd1;
  localparam logic [1:0] REG_SRC_W = 2'd2;
  localparam logic [1:0] REG_SRC_H = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTE, ST_SETUP, ST_READ, ST_WAIT, ST_MERGE, ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic do_byte;
    logic setup;
    logic issue_read;
    logic merge;
    logic step;
    logic load_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
  } stat_t;

  function automatic logic combine(input logic [2:0] op, input logic s, input logic d);
    case (op)
      OP_OR:      combine = s | d;
      OP_AND:     combine = s & d;
      OP_XOR:     combine = s ^ d;
      OP_XNOR:    combine = ~(s ^ d);
      OP_REPLACE: combine = s;
      default:    combine = d;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/bbc_if.sv
// valid/ready channel interfaces for the compose block
// imports bbc_pkg
`default_nettype none
interface bbc_in_if;
  import bbc_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [14:0] byte_addr;
  logic [7:0] byte_data;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic [2:0] op;
  modport source (output valid, func, byte_addr, byte_data, pos_x, pos_y, op, input ready);
  modport sink (input valid, func, byte_addr, byte_data, pos_x, pos_y, op, output ready);
endinterface

interface bbc_out_if;
  logic valid;
  logic ready;
  logic [7:0] read_data;
  logic status;
  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

interface bbc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bbc_ctrl.sv
// controller state machine for the compose block
// uses bbc_pkg; drives the datapath by cmd_t, reads stat_t
`default_nettype none
module bbc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [1:0] in_func,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire bbc_pkg::stat_t stat,
  output bbc_pkg::cmd_t cmd
);
  import bbc_pkg::*;
  state_t state, state_next;
  logic ovalid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && (!ovalid || out_ready))
        state_next = (in_func == FUNC_COMPOSE) ? ST_SETUP : ST_BYTE;
      ST_BYTE: state_next = ST_RESULT;
      ST_SETUP: state_next = stat.empty ? ST_RESULT : ST_READ;
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_MERGE;
      ST_MERGE: state_next = stat.last ? ST_RESULT : ST_READ;
      ST_RESULT: if (!ovalid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !ovalid || out_ready;
        cmd.take_item = in_valid && in_ready;
      end
      ST_BYTE: cmd.do_byte = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_READ: cmd.issue_read = 1'b1;
      ST_MERGE: begin
        cmd.merge = 1'b1;
        cmd.step = 1'b1;
      end
      ST_RESULT: cmd.load_result = !ovalid || out_ready;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) ovalid <= 1'b1;
      else if (out_ready) ovalid <= 1'b0;
    end
  end
  assign out_valid = ovalid;
endmodule
`default_nettype wire

FILE: rtl/core/bbc_dp.sv
// datapath: config registers, the two byte stores and the pixel walker
// uses bbc_pkg; commanded by bbc_ctrl
`default_nettype none
module bbc_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bbc_pkg::cmd_t cmd,
  output bbc_pkg::stat_t stat,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  input  wire logic [1:0] in_func,
  input  wire logic [14:0] in_addr,
  input  wire logic [7:0] in_data,
  input  wire logic signed [9:0] in_x,
  input  wire logic signed [9:0] in_y,
  input  wire logic [2:0] in_op,
  output logic [7:0] read_data,
  output logic status
);
  import bbc_pkg::*;

  logic [7:0] dst_mem [DST_DEPTH];
  logic [7:0] src_mem [SRC_DEPTH];

  logic [9:0] dst_width, dst_height;
  logic [8:0] src_width, src_height;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_width <= 10'd512; dst_height <= 10'd512;
      src_width <= 9'd256; src_height <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DST_W: dst_width <= cfg_data;
        REG_DST_H: dst_height <= cfg_data;
        REG_SRC_W: src_width <= cfg_data[8:0];
        REG_SRC_H: src_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions, 1..max
  logic [9:0] dw, dh;
  logic [8:0] sw, sh;
  always_comb begin
    dw = (dst_width == 0) ? 10'd1
       : (dst_width > 10'(DST_MAX_DIM) ? 10'(DST_MAX_DIM) : dst_width);
    dh = (dst_height == 0) ? 10'd1
       : (dst_height > 10'(DST_MAX_DIM) ? 10'(DST_MAX_DIM) : dst_height);
    sw = (src_width == 0) ? 9'd1
       : (src_width > 9'(SRC_MAX_DIM) ? 9'(SRC_MAX_DIM) : src_width);
    sh = (src_height == 0) ? 9'd1
       : (src_height > 9'(SRC_MAX_DIM) ? 9'(SRC_MAX_DIM) : src_height);
  end
  logic [6:0] dstride;
  logic [5:0] sstride;
  assign dstride = 7'((11'(dw) + 11'd7) >> 3);
  assign sstride = 6'((10'(sw) + 10'd7) >> 3);

  // latched item
  logic [1:0] func;
  logic [14:0] addr;
  logic [7:0] data;
  logic signed [9:0] px, py;
  logic [2:0] op;
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      func <= in_func; addr <= in_addr; data <= in_data;
      px <= in_x; py <= in_y; op <= in_op;
    end
  end

  // byte-item size check, one multiply per bitmap
  logic [16:0] dsize;
  logic [14:0] ssize;
  assign dsize = 17'(dstride) * 17'(dh);
  assign ssize = 15'(sstride) * 15'(sh);
  logic in_range;
  always_comb begin
    if (func == FUNC_WR_SRC) in_range = {2'b0, addr} < ssize;
    else in_range = {2'b0, addr} < dsize;
  end

  // clip setup; registers of the walk
  logic signed [11:0] cx1, cy1; // clipped dest window, exclusive end
  logic [9:0] dcol, drow;
  logic [8:0] scol, srow;
  logic [8:0] scol0;
  logic [9:0] dcol0;
  logic signed [11:0] ex, ey, ex1, ey1;
  always_comb begin
    ex = (px < 0) ? 12'sd0 : 12'(px);
    ey = (py < 0) ? 12'sd0 : 12'(py);
    ex1 = 12'(px) + 12'(sw);
    ey1 = 12'(py) + 12'(sh);
    if (ex1 > $signed({2'b00, dw})) ex1 = $signed({2'b00, dw});
    if (ey1 > $signed({2'b00, dh})) ey1 = $signed({2'b00, dh});
  end
  assign stat.empty = (ex1 <= ex) || (ey1 <= ey) || (op > OP_REPLACE);
  assign stat.last = (12'(dcol) + 12'sd1 == cx1) && (12'(drow) + 12'sd1 == cy1);

  // addresses of the current pixel
  logic [DA_W-1:0] daddr;
  logic [SA_W-1:0] saddr;
  assign daddr = DA_W'(drow) * DA_W'(dstride) + DA_W'(dcol >> 3);
  assign saddr = SA_W'(srow) * SA_W'(sstride) + SA_W'(scol >> 3);

  logic [7:0] dq, sq;
  logic [7:0] mbyte;
  logic r;
  always_comb begin
    r = combine(op, sq[3'd7 - scol[2:0]], dq[3'd7 - dcol[2:0]]);
    mbyte = dq;
    mbyte[3'd7 - dcol[2:0]] = r;
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cx1 <= ex1; cy1 <= ey1;
      dcol <= 10'(ex); drow <= 10'(ey); dcol0 <= 10'(ex);
      scol <= 9'(ex - 12'(px)); scol0 <= 9'(ex - 12'(px));
      srow <= 9'(ey - 12'(py));
    end else if (cmd.step) begin
      if (12'(dcol) + 12'sd1 == cx1) begin
        dcol <= dcol0; scol <= scol0;
        drow <= drow + 10'd1; srow <= srow + 9'd1;
      end else begin
        dcol <= dcol + 10'd1; scol <= scol + 9'd1;
      end
    end
  end

  // memories
  logic [7:0] rd_q;
  always_ff @(posedge clk) begin
    if (cmd.do_byte && in_range && func == FUNC_WR_DST)
      dst_mem[addr[DA_W-1:0]] <= data;
    else if (cmd.merge)
      dst_mem[daddr] <= mbyte;
    if (cmd.issue_read) dq <= dst_mem[daddr];
    if (cmd.do_byte) rd_q <= dst_mem[addr[DA_W-1:0]];
  end
  always_ff @(posedge clk) begin
    if (cmd.do_byte && in_range && func == FUNC_WR_SRC)
      src_mem[addr[SA_W-1:0]] <= data;
    if (cmd.issue_read) sq <= src_mem[saddr];
  end

  // result
  logic bad;
  always_ff @(posedge clk) begin
    if (cmd.do_byte) bad <= !in_range;
    else if (cmd.setup) bad <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status <= bad;
      read_data <= (func == FUNC_RD_DST && !bad) ? rd_q : 8'd0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/bilevel_bitmap_compose.sv
// top level of the bilevel bitmap compose block
// uses bbc_pkg, bbc_if, bbc_ctrl and bbc_dp
//
// in: one word per item (func, byte_addr, byte_data, pos_x, pos_y, op).
// out: one word per item (read_data, status). cfg: register index, data.
// byte items (write dst, write src, read dst) reach the result register
// in order: latch, store access, result load.
// a compose walks the N clipped pixels after setup: each pixel needs a
// registered read of both stores and a merge write back to the single
// destination port, one pixel at a time. empty clips go straight to result.
// one item is in work at a time; the next is taken once the result
// register is free or being drained.
// reset sets dimensions to 512/512/256/256 and empties the output
// register; store contents are undefined until written, no clear pass.
// when the receiver stalls, the result holds and no new item is taken.
// configuration is always ready and must be written while idle.
`default_nettype none
module bilevel_bitmap_compose (
  input wire logic clk,
  input wire logic rst,
  bbc_in_if.sink in_ch,
  bbc_out_if.source out_ch,
  bbc_cfg_if.sink cfg
);
  import bbc_pkg::*;
  cmd_t cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  bbc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_func(in_ch.func), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  bbc_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .in_func(in_ch.func), .in_addr(in_ch.byte_addr), .in_data(in_ch.byte_data),
    .in_x(in_ch.pos_x), .in_y(in_ch.pos_y), .in_op(in_ch.op),
    .read_data(out_ch.read_data), .status(out_ch.status)
  );
endmodule
`default_nettype wire

FILE: rtl/core/bbc_checker.sv
// port-level checks for the compose block
// bound to bilevel_bitmap_compose; sees its ports only
`default_nettype none
module bbc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [7:0] read_data,
  input wire logic status
);
  // a result word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("result changed while stalled");
  // no second item is taken in the cycle after an accept
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during work");
  // a failed byte access never returns data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == 8'd0)
    else $error("data on error status");
  // nothing valid right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind bilevel_bitmap_compose bbc_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .read_data(out_ch.read_data), .status(out_ch.status)
);
`default_nettype wire
